FILE: design/graph_bridge_finder_defines.svh
// ---------------------------------------------------------------------------
// graph_bridge_finder_defines
// assertion macros used by the bridge finder controller
// ---------------------------------------------------------------------------
`ifndef GRAPH_BRIDGE_FINDER_DEFINES_SVH
`define GRAPH_BRIDGE_FINDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define GBF_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GBF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/gbf_pkg.sv
// ---------------------------------------------------------------------------
// gbf_pkg
// types and codes shared by the bridge finder controller and datapath
// ---------------------------------------------------------------------------
package gbf_pkg;

  typedef struct packed {
    logic       command;
    logic [6:0] vertex_a;
    logic [6:0] vertex_b;
    logic       is_last;
    logic [8:0] query_index;
  } request_t;

  typedef struct packed {
    logic       kind;
    logic [8:0] bridge_count;
    logic       is_bridge;
    logic [1:0] status;
  } result_t;

  localparam logic       CMD_LOAD     = 1'b0;
  localparam logic       CMD_QUERY    = 1'b1;
  localparam logic       KIND_RUN     = 1'b0;
  localparam logic       KIND_QUERY   = 1'b1;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_QUERY = 2'd3;

  localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUERY,
    OP_RESP_Q,
    OP_RESP_L,
    OP_A_INIT,
    OP_A_RI,
    OP_A_LI,
    OP_A_RJ,
    OP_A_CJ,
    OP_A_WR,
    OP_B_RI,
    OP_B_LI,
    OP_B_CLR,
    OP_P_RD,
    OP_P_LD,
    OP_P_UP,
    OP_T_RD,
    OP_T_WR,
    OP_B_NX
  } op_t;

  typedef struct packed {
    logic load_bad;
    logic empty;
    logic i_last;
    logic j_last;
    logic v_last;
    logic keep_rd;
    logic pass_use;
    logic more;
  } dp_status_t;

endpackage

FILE: design/gbf_ram.sv
// ---------------------------------------------------------------------------
// gbf_ram
// simple dual port ram, one write port and one registered read port
// ---------------------------------------------------------------------------
module gbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/gbf_datapath.sv
// ---------------------------------------------------------------------------
// gbf_datapath
// edge, filter, label and bridge stores with the counters that walk them
// ---------------------------------------------------------------------------
module gbf_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  gbf_pkg::op_t        op,
  input  gbf_pkg::request_t   request,
  input  logic                config_we,
  input  logic [6:0]          config_data,
  output gbf_pkg::dp_status_t st,
  output gbf_pkg::result_t    result,
  output logic                done
);
  import gbf_pkg::*;

  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int CW     = (ECW > 9) ? ECW : 9;
  localparam int VLIM   = (MAX_VERTICES > 127) ? 127 : MAX_VERTICES;
  localparam int VDEPTH = VLIM + 1;
  localparam int VAW    = $clog2(VDEPTH);
  localparam logic [6:0]     VLIM7   = 7'(VLIM);
  localparam logic [ECW-1:0] EMAX    = ECW'(MAX_EDGES);

  logic [6:0]     vertex_count;
  logic [ECW-1:0] edge_total;
  logic [ECW-1:0] bridge_total;
  logic           run_done;
  logic [EAW-1:0] i_cnt;
  logic [EAW-1:0] j_cnt;
  logic [VAW-1:0] v_cnt;
  logic [6:0]     ea;
  logic [6:0]     eb;
  logic [VAW-1:0] pa;
  logic [VAW-1:0] pb;
  logic           keep_cur;
  logic           changed;
  logic [1:0]     load_status;
  logic           load_last;
  logic           q_ok;

  logic [13:0]    e0;
  logic [13:0]    e1;
  logic [6:0]     e0a, e0b, e1a, e1b;
  logic           k0, k1, b_rd;
  logic [VAW-1:0] c0, c1;
  logic [6:0]     n;
  logic [ECW-1:0] tot_eff;
  logic [1:0]     load_st;
  logic           ewe;
  logic           cwe;
  logic [VAW-1:0] cwaddr, cwdata, craddr0, craddr1;
  logic           bwe, bwdata;
  logic [CW-1:0]  qext;
  logic [EAW-1:0] qaddr;
  logic           q_ok_now;
  logic           step;
  logic           c_diff;

  assign e0a = e0[13:7];
  assign e0b = e0[6:0];
  assign e1a = e1[13:7];
  assign e1b = e1[6:0];
  assign n   = (vertex_count < VLIM7) ? vertex_count : VLIM7;

  assign tot_eff = run_done ? '0 : edge_total;
  always_comb begin
    if (request.vertex_a == 7'd0 || request.vertex_b == 7'd0 ||
        request.vertex_a > n || request.vertex_b > n) begin
      load_st = STATUS_RANGE;
    end else if (tot_eff == EMAX) begin
      load_st = STATUS_FULL;
    end else begin
      load_st = STATUS_OK;
    end
  end
  assign ewe = (op == OP_LOAD) && (load_st == STATUS_OK);

  assign qext     = CW'(request.query_index);
  assign qaddr    = EAW'(qext - CW'(1));
  assign q_ok_now = run_done && (request.query_index != 9'd0) && (qext <= CW'(edge_total));

  assign c_diff = (c0 != c1);
  assign cwe    = (op == OP_B_CLR) || ((op == OP_P_UP) && c_diff);
  assign cwaddr = (op == OP_B_CLR) ? v_cnt : ((c0 < c1) ? pb : pa);
  assign cwdata = (op == OP_B_CLR) ? v_cnt : ((c0 < c1) ? c0 : c1);
  assign craddr0 = (op == OP_T_RD) ? ea[VAW-1:0] : e1a[VAW-1:0];
  assign craddr1 = (op == OP_T_RD) ? eb[VAW-1:0] : e1b[VAW-1:0];

  assign bwe    = ((op == OP_B_LI) && !k0) || (op == OP_T_WR);
  assign bwdata = (op == OP_T_WR) && c_diff;

  assign st.load_bad = (load_st != STATUS_OK);
  assign st.empty    = (edge_total == '0);
  assign st.i_last   = (ECW'(i_cnt) + ECW'(1)) == edge_total;
  assign st.j_last   = (ECW'(j_cnt) + ECW'(1)) == edge_total;
  assign st.v_last   = (7'(v_cnt) == n);
  assign st.keep_rd  = k0;
  assign st.pass_use = k1 && (j_cnt != i_cnt);
  assign st.more     = changed || ((op == OP_P_UP) && c_diff);

  assign step = ((op == OP_P_LD) && !st.pass_use) || (op == OP_P_UP);

  gbf_ram #(.WIDTH(14), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge0 (
    .clk(clk), .we(ewe), .waddr(tot_eff[EAW-1:0]),
    .wdata({request.vertex_a, request.vertex_b}), .raddr(i_cnt), .rdata(e0)
  );
  gbf_ram #(.WIDTH(14), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge1 (
    .clk(clk), .we(ewe), .waddr(tot_eff[EAW-1:0]),
    .wdata({request.vertex_a, request.vertex_b}), .raddr(j_cnt), .rdata(e1)
  );
  gbf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES), .AW(EAW)) u_keep0 (
    .clk(clk), .we(op == OP_A_WR), .waddr(i_cnt), .wdata(keep_cur),
    .raddr(i_cnt), .rdata(k0)
  );
  gbf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES), .AW(EAW)) u_keep1 (
    .clk(clk), .we(op == OP_A_WR), .waddr(i_cnt), .wdata(keep_cur),
    .raddr(j_cnt), .rdata(k1)
  );
  gbf_ram #(.WIDTH(VAW), .DEPTH(VDEPTH), .AW(VAW)) u_comp0 (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata),
    .raddr(craddr0), .rdata(c0)
  );
  gbf_ram #(.WIDTH(VAW), .DEPTH(VDEPTH), .AW(VAW)) u_comp1 (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata),
    .raddr(craddr1), .rdata(c1)
  );
  gbf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES), .AW(EAW)) u_bridge (
    .clk(clk), .we(bwe), .waddr(i_cnt), .wdata(bwdata),
    .raddr(qaddr), .rdata(b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      edge_total   <= '0;
      bridge_total <= '0;
      run_done     <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= (op == OP_RESP_Q) || (op == OP_RESP_L);
      if (config_we) begin
        vertex_count <= config_data;
      end
      if (step) begin
        if (st.j_last) begin
          j_cnt   <= '0;
          changed <= 1'b0;
        end else begin
          j_cnt <= j_cnt + EAW'(1);
        end
      end
      unique case (op)
        OP_LOAD: begin
          if (run_done) begin
            bridge_total <= '0;
          end
          run_done    <= 1'b0;
          edge_total  <= tot_eff + ECW'(ewe);
          load_status <= load_st;
          load_last   <= request.is_last;
        end
        OP_QUERY: begin
          q_ok <= q_ok_now;
        end
        OP_RESP_Q: begin
          result <= '{kind: KIND_QUERY, bridge_count: 9'(bridge_total),
                      is_bridge: q_ok & b_rd,
                      status: q_ok ? STATUS_OK : STATUS_QUERY};
        end
        OP_RESP_L: begin
          result <= '{kind: KIND_RUN,
                      bridge_count: load_last ? 9'(bridge_total) : 9'd0,
                      is_bridge: 1'b0, status: load_status};
          if (load_last) begin
            run_done <= 1'b1;
          end
        end
        OP_A_INIT: begin
          i_cnt        <= '0;
          bridge_total <= '0;
        end
        OP_A_LI: begin
          ea       <= e0a;
          eb       <= e0b;
          keep_cur <= (e0a != e0b) && (e0a <= n) && (e0b <= n);
          j_cnt    <= '0;
        end
        OP_A_CJ: begin
          if ((j_cnt != i_cnt) &&
              (((e1a == ea) && (e1b == eb)) || ((e1a == eb) && (e1b == ea)))) begin
            keep_cur <= 1'b0;
          end
          j_cnt <= j_cnt + EAW'(1);
        end
        OP_A_WR: begin
          i_cnt <= st.i_last ? '0 : i_cnt + EAW'(1);
        end
        OP_B_LI: begin
          ea      <= e0a;
          eb      <= e0b;
          v_cnt   <= VAW'(1);
          j_cnt   <= '0;
          changed <= 1'b0;
        end
        OP_B_CLR: begin
          v_cnt <= v_cnt + VAW'(1);
        end
        OP_P_LD: begin
          pa <= e1a[VAW-1:0];
          pb <= e1b[VAW-1:0];
        end
        OP_P_UP: begin
          if (c_diff && !st.j_last) begin
            changed <= 1'b1;
          end
        end
        OP_T_WR: begin
          bridge_total <= bridge_total + ECW'(c_diff);
        end
        OP_B_NX: begin
          i_cnt <= i_cnt + EAW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/gbf_controller.sv
// ---------------------------------------------------------------------------
// gbf_controller
// sequencer for loading, filtering, bridge testing and answering requests
// ---------------------------------------------------------------------------
`include "graph_bridge_finder_defines.svh"

module gbf_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  logic                is_last,
  input  gbf_pkg::dp_status_t st,
  output gbf_pkg::op_t        op,
  output logic                busy
);
  import gbf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_QRESP, S_LRESP, S_AINIT, S_ARI, S_ALI, S_ARJ, S_ACJ, S_AWR,
    S_BRI, S_BLI, S_BCLR, S_PRD, S_PLD, S_PUP, S_TRD, S_TWR, S_BNX
  } state_t;

  state_t state, state_next;
  logic   pass_end;

  assign pass_end = st.j_last && !st.more;

  always_comb begin
    unique case (state)
      S_IDLE:  op = start ? ((command == CMD_QUERY) ? OP_QUERY : OP_LOAD) : OP_NONE;
      S_QRESP: op = OP_RESP_Q;
      S_LRESP: op = OP_RESP_L;
      S_AINIT: op = OP_A_INIT;
      S_ARI:   op = OP_A_RI;
      S_ALI:   op = OP_A_LI;
      S_ARJ:   op = OP_A_RJ;
      S_ACJ:   op = OP_A_CJ;
      S_AWR:   op = OP_A_WR;
      S_BRI:   op = OP_B_RI;
      S_BLI:   op = OP_B_LI;
      S_BCLR:  op = OP_B_CLR;
      S_PRD:   op = OP_P_RD;
      S_PLD:   op = OP_P_LD;
      S_PUP:   op = OP_P_UP;
      S_TRD:   op = OP_T_RD;
      S_TWR:   op = OP_T_WR;
      S_BNX:   op = OP_B_NX;
      default: op = OP_NONE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_QUERY) begin
            state_next = S_QRESP;
          end else if (is_last) begin
            state_next = S_AINIT;
          end else if (st.load_bad) begin
            state_next = S_LRESP;
          end
        end
      end
      S_QRESP: state_next = S_IDLE;
      S_LRESP: state_next = S_IDLE;
      S_AINIT: state_next = st.empty ? S_LRESP : S_ARI;
      S_ARI:   state_next = S_ALI;
      S_ALI:   state_next = S_ARJ;
      S_ARJ:   state_next = S_ACJ;
      S_ACJ:   state_next = st.j_last ? S_AWR : S_ARJ;
      S_AWR:   state_next = st.i_last ? S_BRI : S_ARI;
      S_BRI:   state_next = S_BLI;
      S_BLI:   state_next = st.keep_rd ? S_BCLR : S_BNX;
      S_BCLR:  state_next = st.v_last ? S_PRD : S_BCLR;
      S_PRD:   state_next = S_PLD;
      S_PLD: begin
        if (st.pass_use) begin
          state_next = S_PUP;
        end else begin
          state_next = pass_end ? S_TRD : S_PRD;
        end
      end
      S_PUP:   state_next = pass_end ? S_TRD : S_PRD;
      S_TRD:   state_next = S_TWR;
      S_TWR:   state_next = S_BNX;
      S_BNX:   state_next = st.i_last ? S_LRESP : S_BRI;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  `GBF_ASSERT_NEXT(a_query_answer, start && !busy && command == CMD_QUERY, state == S_QRESP, "request not answered")
  `GBF_ASSERT_IMPLY(a_busy_state, 1'b1, busy == (state != S_IDLE), "busy out of step with state")
  `GBF_ASSERT_NEXT(a_pass_flow, state == S_PUP, state == S_PRD || state == S_TRD, "label pass lost its place")

endmodule

FILE: design/graph_bridge_finder.sv
// ---------------------------------------------------------------------------
// graph_bridge_finder
// bridge finder over an undirected graph loaded one edge per request
//
//   channel   signals                    handshake
//   request   start, request             taken when start && !busy
//   result    done, result               one cycle pulse, never stalled
//   config    config_we, config_data     written when config_we
//
// load without a result: handled in the idle state; query or bad load: a response state follows
// last edge: the duplicate filter over every pair of edges, then for each kept
//   edge n label clears plus up to n label passes over the edge store,
//   with n vertices in use
// reset: synchronous, stores need no clearing pass
// ---------------------------------------------------------------------------
module graph_bridge_finder #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gbf_pkg::request_t request,
  output logic              done,
  output gbf_pkg::result_t  result,
  input  logic              config_we,
  input  logic [6:0]        config_data
);
  import gbf_pkg::*;

  op_t        op;
  dp_status_t st;

  gbf_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(request.command),
    .is_last(request.is_last), .st(st), .op(op), .busy(busy)
  );

  gbf_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .op(op), .request(request), .config_we(config_we),
    .config_data(config_data), .st(st), .result(result), .done(done)
  );

endmodule
